[hdl/bxds_pkg.sv]
// ----------------------------------------------------------------------------
// bxds_pkg
// shared constants, types and codes of the box average downscaler
// ----------------------------------------------------------------------------
package bxds_pkg;

	localparam int MAX_OUT_WIDTH = 1024;
	localparam int MAX_SCALE     = 16;
	localparam int SAMPLE_BITS   = 16;
	localparam int CHANNELS      = 4;

	localparam int FIELD_W      = 16;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_W     = 16;
	localparam int SCALE_REG_W  = 5;
	localparam int IDX_W        = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int TDATA_W      = CHANNELS * FIELD_W;

	localparam int COL_W   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int EFFW_W  = $clog2(MAX_OUT_WIDTH + 1);
	localparam int SUB_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int SCALE_W = $clog2(MAX_SCALE + 1);
	localparam int SUM_W   = SAMPLE_BITS + 2 * SUB_W;
	localparam int REM_W   = 2 * SUB_W + 1;
	localparam int CNT_W   = $clog2(SAMPLE_BITS);
	localparam int RAM_W   = CHANNELS * SUM_W;

	typedef enum logic [IDX_W-1:0] {
		REG_OUT_WIDTH  = 2'd0,
		REG_OUT_HEIGHT = 2'd1,
		REG_SCALE      = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [EFFW_W-1:0]   width;
		logic [HEIGHT_W-1:0] height;
		logic [SCALE_W-1:0]  scale;
		logic [REM_W-1:0]    area;
		logic                clear;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic acc;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_blk;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

[hdl/box_average_downscaler_unit.sv]
// ----------------------------------------------------------------------------
// box_average_downscaler_unit
// box filter downscaler for a raster stream of four-channel pixels
// ----------------------------------------------------------------------------
// an item that completes no block: column sum ram read, then add and write
// an item that completes a block also runs a 16-step divider, then waits for a free result register
// result shows on m_tvalid once the output register is loaded after the divider's last step
// one result register lets the next item in while a result waits
// reset clears counters and state, sets the configuration registers to 1; sum ram is not cleared
module box_average_downscaler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bxds_pkg::TDATA_W-1:0]    s_tdata,  // in_red, in_green, in_blue, in_alpha
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bxds_pkg::TDATA_W-1:0]    m_tdata,  // out_red, out_green, out_blue, out_alpha
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bxds_pkg::IDX_W-1:0]      cfg_index,
	input  logic [bxds_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bxds_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	bxds_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	bxds_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bxds_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

[hdl/bxds_ram.sv]
// ----------------------------------------------------------------------------
// bxds_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bxds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/bxds_cfg.sv]
// ----------------------------------------------------------------------------
// bxds_cfg
// configuration registers, kept as clamped working values
// ----------------------------------------------------------------------------
module bxds_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bxds_pkg::IDX_W-1:0]      cfg_index,
	input  logic [bxds_pkg::CFG_DATA_W-1:0] cfg_data,
	output bxds_pkg::cfg_t                  cfg
);
	import bxds_pkg::*;

	logic [EFFW_W-1:0]      width_q, width_d;
	logic [HEIGHT_W-1:0]    height_q, height_d;
	logic [SCALE_W-1:0]     scale_q, scale_d;
	logic [REM_W-1:0]       area_q, area_d;
	logic [WIDTH_REG_W-1:0] wv;
	logic [HEIGHT_W-1:0]    hv;
	logic [SCALE_REG_W-1:0] sv;
	logic [2*SCALE_W-1:0]   prod;
	logic                   wr;

	assign cfg_ready = 1'b1;
	assign wv = cfg_data[WIDTH_REG_W-1:0];
	assign hv = cfg_data[HEIGHT_W-1:0];
	assign sv = cfg_data[SCALE_REG_W-1:0];

	always_comb begin
		if (wv == '0) begin
			width_d = EFFW_W'(1);
		end else if (32'(wv) > MAX_OUT_WIDTH) begin
			width_d = EFFW_W'(MAX_OUT_WIDTH);
		end else begin
			width_d = EFFW_W'(wv);
		end
		height_d = (hv == '0) ? HEIGHT_W'(1) : hv;
		if (sv == '0) begin
			scale_d = SCALE_W'(1);
		end else if (32'(sv) > MAX_SCALE) begin
			scale_d = SCALE_W'(MAX_SCALE);
		end else begin
			scale_d = SCALE_W'(sv);
		end
		prod   = {{SCALE_W{1'b0}}, scale_d} * {{SCALE_W{1'b0}}, scale_d};
		area_d = REM_W'(prod);
	end

	always_comb begin
		case (cfg_index)
			REG_OUT_WIDTH, REG_OUT_HEIGHT, REG_SCALE: wr = cfg_valid;
			default: wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= EFFW_W'(1);
			height_q <= HEIGHT_W'(1);
			scale_q  <= SCALE_W'(1);
			area_q   <= REM_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OUT_WIDTH: width_q <= width_d;
				REG_OUT_HEIGHT: height_q <= height_d;
				REG_SCALE: begin
					scale_q <= scale_d;
					area_q  <= area_d;
				end
				default: ;
			endcase
		end
	end

	assign cfg.width  = width_q;
	assign cfg.height = height_q;
	assign cfg.scale  = scale_q;
	assign cfg.area   = area_q;
	assign cfg.clear  = wr;

endmodule

[hdl/bxds_ctrl.sv]
// ----------------------------------------------------------------------------
// bxds_ctrl
// controller: sequences accumulate per item, divide and result hand-off per block-completing item
// ----------------------------------------------------------------------------
module bxds_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  bxds_pkg::stat_t stat,
	output bxds_pkg::cmd_t  cmd
);
	import bxds_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = stat.last_blk ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (stat.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.take     = 1'b0;
		cmd.acc      = 1'b0;
		cmd.div_step = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_ACC: cmd.acc = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_OUT: cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_acc_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> $past(cmd.take))
		else $error("accumulate step without an accepted item");

	a_out_after_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && $past(state_q) == ST_DIV) |-> $past(stat.div_last))
		else $error("divider left before its last step");
`endif

endmodule

[hdl/bxds_dp.sv]
// ----------------------------------------------------------------------------
// bxds_dp
// datapath: position counters, column sum ram, four-lane divider, output reg
// ----------------------------------------------------------------------------
module bxds_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bxds_pkg::cfg_t               cfg,
	input  bxds_pkg::cmd_t               cmd,
	output bxds_pkg::stat_t              stat,
	input  logic [bxds_pkg::TDATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bxds_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tlast
);
	import bxds_pkg::*;

	logic [SUB_W-1:0]    sub_c_q, sub_r_q;
	logic [COL_W-1:0]    oc_q;
	logic [HEIGHT_W-1:0] orow_q;
	logic                c_end, w_end, r_end, h_end;

	logic [CHANNELS-1:0][SAMPLE_BITS-1:0] pix_s1;
	logic                                 first_s1, last_s1, fl_s1;
	logic [COL_W-1:0]                     addr_s1;

	logic [CHANNELS-1:0][SUM_W-1:0] rd_sum, new_sum;
	logic [RAM_W-1:0]               rdata;

	logic [REM_W-1:0]       rem_q [CHANNELS];
	logic [SAMPLE_BITS-1:0] quo_q [CHANNELS];
	logic [REM_W-1:0]       rem_d [CHANNELS];
	logic [SAMPLE_BITS-1:0] quo_d [CHANNELS];
	logic [REM_W:0]         trial [CHANNELS];
	logic [CNT_W-1:0]       dcnt_q;
	logic                   fl_q;

	logic                                   m_valid_q, m_last_q;
	logic [CHANNELS-1:0][FIELD_W-1:0]       m_data_q;

	assign c_end = SCALE_W'(sub_c_q) == cfg.scale - SCALE_W'(1);
	assign r_end = SCALE_W'(sub_r_q) == cfg.scale - SCALE_W'(1);
	assign w_end = EFFW_W'(oc_q) == cfg.width - EFFW_W'(1);
	assign h_end = orow_q == cfg.height - HEIGHT_W'(1);

	// raster position of the next source pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_c_q <= '0;
			sub_r_q <= '0;
			oc_q    <= '0;
			orow_q  <= '0;
		end else if (cfg.clear) begin
			sub_c_q <= '0;
			sub_r_q <= '0;
			oc_q    <= '0;
			orow_q  <= '0;
		end else if (cmd.take) begin
			if (!c_end) begin
				sub_c_q <= sub_c_q + SUB_W'(1);
			end else begin
				sub_c_q <= '0;
				if (!w_end) begin
					oc_q <= oc_q + COL_W'(1);
				end else begin
					oc_q <= '0;
					if (!r_end) begin
						sub_r_q <= sub_r_q + SUB_W'(1);
					end else begin
						sub_r_q <= '0;
						orow_q  <= h_end ? '0 : orow_q + HEIGHT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			for (int k = 0; k < CHANNELS; k++) begin
				pix_s1[k] <= SAMPLE_BITS'(s_tdata[k*FIELD_W +: FIELD_W]);
			end
			first_s1 <= (sub_c_q == '0) && (sub_r_q == '0);
			last_s1  <= c_end && r_end;
			fl_s1    <= w_end && h_end;
			addr_s1  <= oc_q;
		end
	end

	bxds_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_OUT_WIDTH)
	) u_sums (
		.clk  (clk),
		.we   (cmd.acc),
		.waddr(addr_s1),
		.wdata(new_sum),
		.re   (cmd.take),
		.raddr(oc_q),
		.rdata(rdata)
	);

	assign rd_sum = rdata;

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			new_sum[k] = first_s1 ? SUM_W'(pix_s1[k]) : rd_sum[k] + SUM_W'(pix_s1[k]);
		end
	end

	// restoring divide by the block area, one quotient bit per step
	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			trial[k] = {rem_q[k], quo_q[k][SAMPLE_BITS-1]};
			if (trial[k] >= {1'b0, cfg.area}) begin
				rem_d[k] = REM_W'(trial[k] - {1'b0, cfg.area});
				quo_d[k] = {quo_q[k][SAMPLE_BITS-2:0], 1'b1};
			end else begin
				rem_d[k] = trial[k][REM_W-1:0];
				quo_d[k] = {quo_q[k][SAMPLE_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			for (int k = 0; k < CHANNELS; k++) begin
				rem_q[k] <= REM_W'(new_sum[k][SUM_W-1:SAMPLE_BITS]);
				quo_q[k] <= new_sum[k][SAMPLE_BITS-1:0];
			end
			fl_q <= fl_s1;
		end else if (cmd.div_step) begin
			for (int k = 0; k < CHANNELS; k++) begin
				rem_q[k] <= rem_d[k];
				quo_q[k] <= quo_d[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.acc) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int k = 0; k < CHANNELS; k++) begin
				m_data_q[k] <= FIELD_W'(quo_q[k]);
			end
			m_last_q <= fl_q;
		end
	end

	assign stat.last_blk = last_s1;
	assign stat.div_last = dcnt_q == CNT_W'(SAMPLE_BITS - 1);
	assign stat.out_free = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTH
	a_sub_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		SCALE_W'(sub_c_q) < cfg.scale && SCALE_W'(sub_r_q) < cfg.scale)
		else $error("block sub-position out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		EFFW_W'(oc_q) < cfg.width && orow_q < cfg.height)
		else $error("output position out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_valid_q || m_tready))
		else $error("result loaded over an untaken item");
`endif

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the box average downscaler: directed and random raster frames
// over several sizes and scales, each output pixel checked against a
// block-mean predictor kept in step with accepted items and register writes
// ----------------------------------------------------------------------------
module testbench;

	import bxds_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_WAIT  = 25;

	typedef logic [CHANNELS-1:0][FIELD_W-1:0] pixel_t;

	typedef struct {
		pixel_t mean;
		logic   frame_end;
	} block_mean_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pixel_t      source_pixels[$];
	block_mean_t pending_means[$];

	// predictor state
	logic [WIDTH_REG_W-1:0] width_reg = 1;
	logic [HEIGHT_W-1:0]    height_reg = 1;
	logic [SCALE_REG_W-1:0] scale_reg = 1;
	int unsigned            column_sum[CHANNELS][MAX_OUT_WIDTH];
	int unsigned            next_col = 0;
	int unsigned            next_row = 0;

	int error_count = 0;
	int send_idle = 14;
	int recv_idle = 55;
	int hold_request = 0;
	int hold_seen = 0;
	int hold_left = 0;

	string field_name[CHANNELS] = '{"out_red", "out_green", "out_blue", "out_alpha"};

	box_average_downscaler_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic void load_register(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_OUT_WIDTH: width_reg = value[WIDTH_REG_W-1:0];
			REG_OUT_HEIGHT: height_reg = value[HEIGHT_W-1:0];
			REG_SCALE: scale_reg = value[SCALE_REG_W-1:0];
			default: return;
		endcase
		next_col = 0;
		next_row = 0;
	endfunction

	function automatic void accumulate_pixel(pixel_t px);
		int unsigned w, h, s, col, row, oc;
		logic        first, last;
		block_mean_t res;
		int          ch;
		w = (width_reg == 0) ? 1 : (width_reg > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		s = (scale_reg == 0) ? 1 : (scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg;
		col = next_col;
		row = next_row;
		if (col >= w * s || row >= h * s) begin
			col = 0;
			row = 0;
		end
		oc = col / s;
		first = (col % s == 0) && (row % s == 0);
		last = (col % s == s - 1) && (row % s == s - 1);
		if (oc >= MAX_OUT_WIDTH)
			oc = MAX_OUT_WIDTH - 1;
		for (ch = 0; ch < CHANNELS; ch++) begin
			if (first)
				column_sum[ch][oc] = px[ch];
			else
				column_sum[ch][oc] += px[ch];
		end
		if (last) begin
			for (ch = 0; ch < CHANNELS; ch++)
				res.mean[ch] = FIELD_W'(column_sum[ch][oc] / (s * s));
			res.frame_end = (oc == w - 1) && (row / s == h - 1);
			pending_means.push_back(res);
		end
		col++;
		if (col >= w * s) begin
			col = 0;
			row++;
			if (row >= h * s)
				row = 0;
		end
		next_col = col;
		next_row = row;
	endfunction

	function automatic pixel_t make_pixel(logic [15:0] r, g, b, a);
		return {a, b, g, r};
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		int     ch;
		for (ch = 0; ch < CHANNELS; ch++) begin
			case ($urandom_range(7))
				0: px[ch] = '0;
				1: px[ch] = '1;
				default: px[ch] = FIELD_W'($urandom);
			endcase
		end
		return px;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned value, int bits);
		logic [CFG_DATA_W-1:0] mask;
		mask = (CFG_DATA_W'(1) << bits) - 1'b1;
		return (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(value) & mask);
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input logic [CFG_DATA_W-1:0] width_word, height_word, scale_word);
		write_reg(REG_OUT_WIDTH, width_word);
		write_reg(REG_OUT_HEIGHT, height_word);
		write_reg(REG_SCALE, scale_word);
	endtask

	task automatic push_random(input int n);
		repeat (n) source_pixels.push_back(random_pixel());
	endtask

	// wait until every item is in and every mean is out, then let the block go idle
	task automatic settle();
		do @(negedge clk);
		while (source_pixels.size() != 0 || s_tvalid || pending_means.size() != 0);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic random_frames(input int count);
		int w, h, s;
		repeat (count) begin
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 3);
			s = $urandom_range(1, 5);
			settle();
			set_frame(with_noise(w, WIDTH_REG_W), CFG_DATA_W'(h), with_noise(s, SCALE_REG_W));
			push_random($urandom_range(20, 40));
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				accumulate_pixel(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (source_pixels.size() != 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tdata <= source_pixels.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// register writes seen by the predictor
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			load_register(cfg_index, cfg_data);
	end

	// result side, with long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_request) begin
			hold_seen <= hold_request;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle;
		end
	end

	always @(posedge clk) begin : result_check
		block_mean_t want;
		int          ch;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_means.size() == 0) begin
				$error("result item with none expected: tdata %h tlast %b", m_tdata, m_tlast);
				error_count++;
			end else begin
				want = pending_means.pop_front();
				for (ch = 0; ch < CHANNELS; ch++) begin
					if (m_tdata[ch*FIELD_W +: FIELD_W] !== want.mean[ch]) begin
						$error("%s expected %h actual %h", field_name[ch], want.mean[ch],
							m_tdata[ch*FIELD_W +: FIELD_W]);
						error_count++;
					end
				end
				if (m_tlast !== want.frame_end) begin
					$error("frame_last expected %b actual %b", want.frame_end, m_tlast);
					error_count++;
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 1x1 frame, every pixel passes through and ends the frame
		source_pixels.push_back(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		source_pixels.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		source_pixels.push_back(make_pixel(16'h5555, 16'h5555, 16'h5555, 16'h5555));
		source_pixels.push_back(make_pixel(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA));

		// zero width and height act as one; 2x2 mean with truncation
		settle();
		set_frame(16'h0000, 16'h0000, 16'h0002);
		repeat (3) source_pixels.push_back(make_pixel(16'hFFFF, 16'h0000, 16'h0001, 16'h8000));
		source_pixels.push_back(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF));

		// masked register bits, frame wrap into the next frame
		settle();
		set_frame(16'hF803, 16'h0001, 16'hFFE1);
		for (i = 0; i < 5; i++)
			source_pixels.push_back(make_pixel(16'(i), 16'(i << 4), 16'(i << 8), 16'(i << 12)));

		// unused index keeps the position, a real write restarts the block
		settle();
		set_frame(16'h0001, 16'h0001, 16'h0002);
		source_pixels.push_back(make_pixel(16'h0100, 16'h0200, 16'h0300, 16'h0400));
		source_pixels.push_back(make_pixel(16'h0101, 16'h0201, 16'h0301, 16'h0401));
		settle();
		write_reg(REG_SPARE, 16'hFFFF);
		source_pixels.push_back(make_pixel(16'h1000, 16'h2000, 16'h3000, 16'h4000));
		source_pixels.push_back(make_pixel(16'h1003, 16'h2003, 16'h3003, 16'h4003));
		source_pixels.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		source_pixels.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		settle();
		write_reg(REG_SCALE, 16'h0002);
		source_pixels.push_back(make_pixel(16'h0007, 16'h0000, 16'hFFFE, 16'h1234));
		source_pixels.push_back(make_pixel(16'h0001, 16'h0000, 16'hFFFF, 16'h4321));
		source_pixels.push_back(make_pixel(16'h0001, 16'h0001, 16'hFFFF, 16'h0000));
		source_pixels.push_back(make_pixel(16'h0000, 16'h0002, 16'hFFFF, 16'hFFFF));

		random_frames(3);

		settle();
		send_idle = 55;
		recv_idle = 14;
		random_frames(3);

		settle();
		send_idle = 0;
		recv_idle = 0;

		// oversized width acts as the maximum, zero scale as one; receiver holds off
		set_frame(16'h07FF, 16'h0002, 16'h0000);
		@(posedge clk);
		hold_request <= hold_request + 1;
		push_random(150);

		// oversized scale acts as the maximum: all-ones block, then a random one
		settle();
		set_frame(16'h0000, 16'hFFFF, 16'h001F);
		repeat (256) source_pixels.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		push_random(256);

		settle();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
